// ===== rtl/sin_pkg.sv =====
`default_nettype none
package sin_pkg;

   localparam int INDEX_WIDTH = 32;
   localparam int LEN_WIDTH   = INDEX_WIDTH - 1;

   typedef struct packed {
      logic [LEN_WIDTH-1:0]          seq_length;
      logic signed [INDEX_WIDTH-1:0] start_index;
      logic signed [INDEX_WIDTH-1:0] stop_index;
      logic signed [INDEX_WIDTH-1:0] stride;
   } req_type;

   typedef struct packed {
      logic signed [INDEX_WIDTH-1:0] adjusted_start;
      logic signed [INDEX_WIDTH-1:0] adjusted_stop;
      logic [LEN_WIDTH-1:0]          slice_count;
      logic                          step_error;
   } rsp_type;

   // Classified request handed from the front part to the back part.
   typedef struct packed {
      logic                   step_error;
      logic                   backward;
      logic [INDEX_WIDTH-1:0] start;
      logic [INDEX_WIDTH-1:0] stop;
      logic [INDEX_WIDTH-1:0] mag;
   } mid_type;

endpackage
`default_nettype wire

// ===== rtl/sin_front.sv =====
`default_nettype none
module sin_front import sin_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         mid_valid,
   input  wire logic    mid_take,
   output mid_type      mid_data
);

   localparam int QD = 4;
   localparam int PW = $clog2(QD);

   mid_type         q_ff [QD];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]     cnt_ff, cnt_in;
   mid_type         cls;
   logic            bw, push, pop;

   // Wrap a negative index by the length, then clamp into the sequence.
   function automatic logic [INDEX_WIDTH-1:0] clamp_idx(
      input logic [INDEX_WIDTH-1:0] idx,
      input logic [LEN_WIDTH-1:0]   len,
      input logic                   back
   );
      logic signed [INDEX_WIDTH:0] wide, lenx, sum;
      logic [INDEX_WIDTH-1:0]      res;
      wide = {idx[INDEX_WIDTH-1], idx};
      lenx = {2'b00, len};
      sum  = wide + lenx;
      if (idx[INDEX_WIDTH-1]) begin
         if (sum[INDEX_WIDTH]) res = back ? '1 : '0;
         else res = sum[INDEX_WIDTH-1:0];
      end else if (wide >= lenx) begin
         res = back ? (lenx[INDEX_WIDTH-1:0] - 1'b1) : lenx[INDEX_WIDTH-1:0];
      end else begin
         res = idx;
      end
      return res;
   endfunction

   always_comb begin
      bw = req_data.stride[INDEX_WIDTH-1];
      cls.step_error = (req_data.stride == '0);
      cls.backward   = bw;
      cls.mag        = bw ? (~req_data.stride + 1'b1) : req_data.stride;
      if (cls.step_error) begin
         cls.start = '0;
         cls.stop  = '0;
      end else begin
         cls.start = clamp_idx(req_data.start_index, req_data.seq_length, bw);
         cls.stop  = clamp_idx(req_data.stop_index, req_data.seq_length, bw);
      end
   end

   assign req_full  = (cnt_ff == (PW+1)'(QD));
   assign mid_valid = (cnt_ff != '0);
   assign mid_data  = q_ff[rd_ff];
   assign push      = req_push && !req_full;
   assign pop       = mid_take && mid_valid;
   assign wr_in     = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in     = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in    = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= cls;
   end

endmodule
`default_nettype wire

// ===== rtl/sin_back.sv =====
`default_nettype none
module sin_back import sin_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    mid_valid,
   output logic         mid_take,
   input  wire mid_type mid_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   localparam int QW = LEN_WIDTH;   // quotient bits, one per stage

   typedef struct packed {
      logic                   valid;
      logic                   step_error;
      logic                   nonempty;
      logic [INDEX_WIDTH-1:0] start;
      logic [INDEX_WIDTH-1:0] stop;
      logic [INDEX_WIDTH-1:0] mag;
      logic [LEN_WIDTH-1:0]   rem;
      logic [LEN_WIDTH-1:0]   dq;
   } stage_type;

   stage_type            st_ff [QW+1];
   stage_type            st_in [QW+1];
   rsp_type              of_ff [2];
   logic                 of_wr_ff, of_rd_ff;
   logic [1:0]           of_cnt_ff, of_cnt_in;
   logic                 en, of_push, of_pop;
   logic [INDEX_WIDTH:0] diff;
   logic [INDEX_WIDTH:0] trial;
   rsp_type              res;

   assign en       = !(st_ff[QW].valid && (of_cnt_ff == 2'd2));
   assign mid_take = en;

   always_comb begin
      // Span minus one, in the direction of the step.
      if (mid_data.backward)
         diff = {mid_data.start[INDEX_WIDTH-1], mid_data.start}
              + ~{mid_data.stop[INDEX_WIDTH-1], mid_data.stop};
      else
         diff = {mid_data.stop[INDEX_WIDTH-1], mid_data.stop}
              + ~{mid_data.start[INDEX_WIDTH-1], mid_data.start};
      st_in[0].valid      = mid_valid;
      st_in[0].step_error = mid_data.step_error;
      st_in[0].nonempty   = !diff[INDEX_WIDTH];
      st_in[0].start      = mid_data.start;
      st_in[0].stop       = mid_data.stop;
      st_in[0].mag        = mid_data.mag;
      st_in[0].rem        = '0;
      st_in[0].dq         = diff[LEN_WIDTH-1:0];
      trial = '0;
      for (int k = 1; k <= QW; k++) begin
         st_in[k] = st_ff[k-1];
         trial = {1'b0, st_ff[k-1].rem, st_ff[k-1].dq[LEN_WIDTH-1]}
               - {1'b0, st_ff[k-1].mag};
         if (!trial[INDEX_WIDTH]) begin
            st_in[k].rem = trial[LEN_WIDTH-1:0];
            st_in[k].dq  = {st_ff[k-1].dq[LEN_WIDTH-2:0], 1'b1};
         end else begin
            st_in[k].rem = {st_ff[k-1].rem[LEN_WIDTH-2:0], st_ff[k-1].dq[LEN_WIDTH-1]};
            st_in[k].dq  = {st_ff[k-1].dq[LEN_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      res.adjusted_start = st_ff[QW].start;
      res.adjusted_stop  = st_ff[QW].stop;
      res.slice_count    = st_ff[QW].nonempty ? st_ff[QW].dq + 1'b1 : '0;
      res.step_error     = st_ff[QW].step_error;
   end

   assign of_push   = en && st_ff[QW].valid;
   assign of_pop    = rsp_pop && !rsp_empty;
   assign of_cnt_in = of_cnt_ff + 2'(of_push) - 2'(of_pop);
   assign rsp_empty = (of_cnt_ff == 2'd0);
   assign rsp_data  = of_ff[of_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) st_ff[k].valid <= 1'b0;
         of_wr_ff  <= 1'b0;
         of_rd_ff  <= 1'b0;
         of_cnt_ff <= '0;
      end else begin
         if (en) begin
            for (int k = 0; k <= QW; k++) st_ff[k].valid <= st_in[k].valid;
         end
         if (of_push) of_wr_ff <= !of_wr_ff;
         if (of_pop) of_rd_ff <= !of_rd_ff;
         of_cnt_ff <= of_cnt_in;
      end
      if (en) begin
         for (int k = 0; k <= QW; k++) begin
            st_ff[k].step_error <= st_in[k].step_error;
            st_ff[k].nonempty   <= st_in[k].nonempty;
            st_ff[k].start      <= st_in[k].start;
            st_ff[k].stop       <= st_in[k].stop;
            st_ff[k].mag        <= st_in[k].mag;
            st_ff[k].rem        <= st_in[k].rem;
            st_ff[k].dq         <= st_in[k].dq;
         end
      end
      if (of_push) of_ff[of_wr_ff] <= res;
   end

   a_of_bound: assert property (@(posedge clock) disable iff (reset)
      of_cnt_ff != 2'd3) else $error("result queue overflow");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (of_push && res.step_error) |-> (res.slice_count == '0 && res.adjusted_start == '0))
      else $error("zero step gave nonzero result");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!en && st_ff[QW].valid) |=> st_ff[QW].valid)
      else $error("stalled result lost");

endmodule
`default_nettype wire

// ===== rtl/slice_index_normalizer.sv =====
`default_nettype none
// Slice index normalizer.
// A request carries a sequence length, a start, a stop and a stride. The
// block wraps negative indices by the length, clamps them into the sequence
// according to the direction of the stride, and counts the elements that
// the slice selects. A zero stride sets step_error and zeroes the rest.
// Both channels behave as queues: push a request while full is low, and
// pop a response while empty is low; responses come out in request order.
// Throughput is one request per cycle while the receiver keeps popping
// responses. A request passes through the classify queue, the span stage,
// the restoring divider (one quotient bit per stage, LEN_WIDTH stages in
// all) and the response queue, whose head is shown on rsp_data.
// A four-entry queue between the classifier and the divider lets the two
// halves stall independently. When the receiver stops popping, the
// two-entry response queue fills, the divider pipeline freezes in place,
// the middle queue fills and full rises; nothing is dropped.
// Synchronous reset empties all queues and clears the pipeline valid bits.
module slice_index_normalizer import sin_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   // Classified requests between the two halves.
   logic    mid_valid;
   logic    mid_take;
   mid_type mid_data;

   sin_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .mid_valid (mid_valid),
      .mid_take  (mid_take),
      .mid_data  (mid_data)
   );

   sin_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (mid_valid),
      .mid_take  (mid_take),
      .mid_data  (mid_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== sim/slice_index_normalizer_tb.sv =====
`timescale 1ns / 100ps
module slice_index_normalizer_tb;
   import sin_pkg::*;

   // The block has a deep divider pipeline; allow that many cycles to drain.
   localparam int PIPE_LATENCY = 40;
   localparam int RANDOM_ITEMS = 1550;
   localparam int MAX_REPORTS  = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_slices[$];
   int      error_count = 0;
   bit      stimulus_done = 1'b0;
   // When set, the receiver pops nothing so that the queues fill. The
   // receiver clears it once its hold-off has run out.
   bit      hold_receiver = 1'b0;

   // One row of the directed table. When has_expected is set, the
   // response typed into the row is checked instead of the predicted one.
   typedef struct {
      req_type request;
      bit      has_expected;
      rsp_type response;
   } directed_row;

   always #5 clock = ~clock;

   slice_index_normalizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Wrap a negative index by the length, then clamp it into the sequence.
   // The direction of the stride picks the clamp bounds.
   function automatic longint clamp_to_sequence(longint idx, longint len, bit backward);
      longint result;
      result = idx;
      if (result < 0) begin
         result = result + len;
         if (result < 0) result = backward ? -1 : 0;
      end else if (result >= len) begin
         result = backward ? len - 1 : len;
      end
      return result;
   endfunction

   // Compute the normalized slice for one request.
   function automatic rsp_type normalize_slice(req_type r);
      rsp_type    o;
      bit         backward;
      longint     len, first, last;
      longint unsigned mag, count;
      o = '0;
      if (r.stride == 0) begin
         o.step_error = 1'b1;
         return o;
      end
      backward = r.stride[INDEX_WIDTH-1];
      // The magnitude is taken in 64 bits so the most negative stride is exact.
      mag = backward ? longint'(-longint'(r.stride)) : longint'(r.stride);
      len = longint'({1'b0, r.seq_length});
      first = clamp_to_sequence(longint'(r.start_index), len, backward);
      last  = clamp_to_sequence(longint'(r.stop_index), len, backward);
      count = 0;
      if (backward) begin
         if (last < first) count = longint'(first - last - 1) / mag + 1;
      end else if (first < last) begin
         count = longint'(last - first - 1) / mag + 1;
      end
      o.adjusted_start = first[INDEX_WIDTH-1:0];
      o.adjusted_stop  = last[INDEX_WIDTH-1:0];
      o.slice_count    = count[LEN_WIDTH-1:0];
      o.step_error     = 1'b0;
      return o;
   endfunction

   function automatic req_type make_request(longint len, longint first, longint last,
                                            longint step);
      req_type r;
      r.seq_length  = len[LEN_WIDTH-1:0];
      r.start_index = first[INDEX_WIDTH-1:0];
      r.stop_index  = last[INDEX_WIDTH-1:0];
      r.stride      = step[INDEX_WIDTH-1:0];
      return r;
   endfunction

   function automatic rsp_type make_response(longint first, longint last, longint count,
                                             bit err);
      rsp_type o;
      o.adjusted_start = first[INDEX_WIDTH-1:0];
      o.adjusted_stop  = last[INDEX_WIDTH-1:0];
      o.slice_count    = count[LEN_WIDTH-1:0];
      o.step_error     = err;
      return o;
   endfunction

   // Random request. Most use short lengths and indices near the sequence so
   // that wrap and clamp paths are exercised; some use full-range values.
   function automatic req_type random_request();
      req_type r;
      int      len;
      int      mode;
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
         len = $urandom_range(0, 40);
         r.seq_length  = LEN_WIDTH'(len);
         r.start_index = $signed($urandom_range(0, 2 * len + 20)) - len - 10;
         r.stop_index  = $signed($urandom_range(0, 2 * len + 20)) - len - 10;
         r.stride      = $signed($urandom_range(0, 16)) - 8;
      end else begin
         r.seq_length  = LEN_WIDTH'($urandom);
         r.start_index = $urandom;
         r.stop_index  = $urandom;
         r.stride      = (mode == 9) ? $signed($urandom_range(0, 6)) - 3 : $urandom;
      end
      return r;
   endfunction

   // Drive one request at the falling edge and hold it until it is accepted.
   task automatic send_request(req_type r, rsp_type exp_rsp);
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      expected_slices.push_back(exp_rsp);
   endtask

   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_push <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stimulus.
   initial begin
      directed_row rows[$];
      directed_row row;
      req_type     r;
      int          burst;
      int          sent;

      // Extremes, the zero stride, the most negative stride and empty spans.
      row.has_expected = 1'b1;
      row.request = make_request(10, 0, 10, 0);
      row.response = make_response(0, 0, 0, 1'b1); rows.push_back(row);
      row.request = make_request(32'h7fffffff, -32'h80000000, 32'h7fffffff, 0);
      rows.push_back(row);
      row.request = make_request(10, 0, 10, 1);
      row.response = make_response(0, 10, 10, 1'b0); rows.push_back(row);
      row.request = make_request(10, 20, -20, -1);
      row.response = make_response(9, -1, 10, 1'b0); rows.push_back(row);
      row.request = make_request(0, 5, 5, 1);
      row.response = make_response(0, 0, 0, 1'b0); rows.push_back(row);
      row.request = make_request(0, 5, -5, -1);
      row.response = make_response(-1, -1, 0, 1'b0); rows.push_back(row);
      row.request = make_request(10, 5, 2, 1);
      row.response = make_response(5, 2, 0, 1'b0); rows.push_back(row);
      row.request = make_request(10, 2, 5, -1);
      row.response = make_response(2, 5, 0, 1'b0); rows.push_back(row);
      row.has_expected = 1'b0;
      row.request = make_request(32'h7fffffff, -32'h80000000, 32'h7fffffff, -32'h80000000);
      rows.push_back(row);
      row.request = make_request(32'h7fffffff, 32'h7fffffff, -32'h80000000, -32'h80000000);
      rows.push_back(row);
      row.request = make_request(32'h7fffffff, -32'h80000000, 32'h7fffffff, 32'h7fffffff);
      rows.push_back(row);
      row.request = make_request(32'h7fffffff, 0, 32'h7fffffff, 1);
      rows.push_back(row);
      row.request = make_request(32'h7fffffff, -1, -32'h80000000, -1);
      rows.push_back(row);
      row.request = make_request(32'h7fffffff, -1, -32'h7fffffff, -32'h7fffffff);
      rows.push_back(row);
      row.request = make_request(100, -3, -50, -7); rows.push_back(row);
      row.request = make_request(100, -300, 300, 3); rows.push_back(row);
      row.request = make_request(7, 1, 6, 2); rows.push_back(row);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_request(rows[i].request,
                      rows[i].has_expected ? rows[i].response :
                      normalize_slice(rows[i].request));

      // Pause until every expected response has come back.
      idle_sender(1);
      while (expected_slices.size() != 0) @(negedge clock);

      // Receiver holds off while the sender keeps offering more requests
      // than the block can hold, so full must rise.
      hold_receiver = 1'b1;
      repeat (80) begin
         r = random_request();
         send_request(r, normalize_slice(r));
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            r = random_request();
            send_request(r, normalize_slice(r));
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(0, 12));
      end
      idle_sender(1);
      stimulus_done = 1'b1;
   end

   // Receiver: stalls in runs of its own, with stretches of steady popping.
   initial begin
      int run;
      int hold;
      forever begin
         @(negedge clock);
         if (hold_receiver) begin
            rsp_pop <= 1'b0;
            // Long hold-off counted here, so the input side backs up.
            for (hold = 0; hold < 60; hold++) @(negedge clock);
            hold_receiver = 1'b0;
         end else begin
            run = $urandom_range(1, 30);
            rsp_pop <= ($urandom_range(0, 2) != 0);
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   // Compare each accepted response against the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_slices.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("Unexpected response %p", rsp_data);
         end else begin
            exp_rsp = expected_slices.pop_front();
            if (rsp_data.adjusted_start !== exp_rsp.adjusted_start ||
                rsp_data.adjusted_stop  !== exp_rsp.adjusted_stop  ||
                rsp_data.slice_count    !== exp_rsp.slice_count    ||
                rsp_data.step_error     !== exp_rsp.step_error) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("Mismatch: expected %p, got %p", exp_rsp, rsp_data);
            end
         end
      end
   end

   // Normal end of the run.
   initial begin
      wait (stimulus_done);
      while (expected_slices.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
      if (error_count == 0 && expected_slices.size() == 0 && rsp_empty)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
